FILE: hw/rtl/prfl_pkg.sv
`default_nettype none

package prfl_pkg;

  localparam int NUM_REGS  = 128;
  localparam int ARCH_REGS = 64;
  localparam int IDX_W     = 7;
  localparam int CNT_W     = 8;
  localparam int CYC_W     = 32;
  localparam int ROW_BITS  = 8;
  localparam int COL_W     = 3;
  localparam int NUM_ROWS  = NUM_REGS / ROW_BITS;
  localparam int ROW_W     = 4;

  localparam logic [2:0] REQ_ALLOC   = 3'd0;
  localparam logic [2:0] REQ_FREE    = 3'd1;
  localparam logic [2:0] REQ_PRODUCE = 3'd2;
  localparam logic [2:0] REQ_PENDING = 3'd3;
  localparam logic [2:0] REQ_QUERY   = 3'd4;

  typedef struct packed {
    logic [2:0]       req_type;
    logic [IDX_W-1:0] reg_index;
    logic [CYC_W-1:0] ready_at;
    logic [CYC_W-1:0] now;
  } req_t;

  typedef struct packed {
    logic             alloc_ok;
    logic [IDX_W-1:0] alloc_index;
    logic             is_ready;
    logic [CNT_W-1:0] in_use_count;
  } resp_t;

  typedef struct packed {
    logic                pending;
    logic [CYC_W-1:0]    ready_cycle;
  } ent_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    ent_t             data;
  } ent_wr_t;

  typedef struct packed {
    logic                we;
    logic [ROW_W-1:0]    row;
    logic [ROW_BITS-1:0] word;
  } map_wr_t;

  // register 0 is never granted: it counts as used in every search
  function automatic logic [ROW_BITS-1:0] row_mask(input logic [ROW_W-1:0] row);
    logic [ROW_BITS-1:0] m;
    m = '0;
    if (row == '0) begin
      m[0] = 1'b1;
    end
    return m;
  endfunction

  function automatic logic [ROW_BITS-1:0] used_reset_row(input logic [ROW_W-1:0] row);
    logic [ROW_BITS-1:0] w;
    int k;
    w = '0;
    for (int b = 0; b < ROW_BITS; b++) begin
      k = int'(row) * ROW_BITS + b;
      w[b] = (k >= 1) && (k < ARCH_REGS);
    end
    return w;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/prfl_ram.sv
`default_nettype none

module prfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/prfl_used_map.sv
`default_nettype none

module prfl_used_map
  import prfl_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [ROW_W-1:0]    rd_row,
  output logic      [ROW_BITS-1:0] rd_word,
  output logic      [ROW_W-1:0]    free_row,
  output logic                     any_free,
  input  wire map_wr_t             wr
);

  logic [ROW_BITS-1:0] ram_q;
  logic [NUM_ROWS-1:0] row_valid;
  logic [NUM_ROWS-1:0] full;
  logic                rd_valid;
  logic [ROW_W-1:0]    rd_row_q;

  prfl_ram #(
    .WIDTH(ROW_BITS),
    .DEPTH(NUM_ROWS)
  ) u_ram (
    .clk  (clk),
    .we   (wr.we),
    .waddr(wr.row),
    .wdata(wr.word),
    .raddr(rd_row),
    .rdata(ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      for (int r = 0; r < NUM_ROWS; r++) begin
        full[r] <= &(used_reset_row(ROW_W'(r)) | row_mask(ROW_W'(r)));
      end
    end else if (wr.we) begin
      row_valid[wr.row] <= 1'b1;
      full[wr.row]      <= &(wr.word | row_mask(wr.row));
    end
    rd_valid <= row_valid[rd_row];
    rd_row_q <= rd_row;
  end

  assign rd_word = rd_valid ? ram_q : used_reset_row(rd_row_q);

  always_comb begin
    free_row = '0;
    for (int r = NUM_ROWS - 1; r >= 0; r--) begin
      if (!full[r]) begin
        free_row = ROW_W'(r);
      end
    end
  end

  assign any_free = ~&full;

endmodule

`default_nettype wire

FILE: hw/rtl/prfl_entry_table.sv
`default_nettype none

module prfl_entry_table
  import prfl_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [IDX_W-1:0] rd_addr,
  output ent_t                  rd_data,
  input  wire ent_wr_t          wr
);

  ent_t                ram_q;
  logic [NUM_REGS-1:0] valid;
  logic                rd_valid;

  prfl_ram #(
    .WIDTH($bits(ent_t)),
    .DEPTH(NUM_REGS)
  ) u_ram (
    .clk  (clk),
    .we   (wr.we),
    .waddr(wr.addr),
    .wdata(wr.data),
    .raddr(rd_addr),
    .rdata(ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr.we) begin
      valid[wr.addr] <= 1'b1;
    end
    rd_valid <= valid[rd_addr];
  end

  assign rd_data = rd_valid ? ram_q : '0;

endmodule

`default_nettype wire

FILE: hw/rtl/phys_reg_free_list_scoreboard.sv
`default_nettype none

// Physical register pool with ready scoreboard. A request is taken when start
// is high and busy is low. Each request first reads the used-flag map (16 rows
// of 8 flags) and the per-register entry memory, and then updates both and
// forms the answer. The answer shows on resp for exactly one cycle with done
// high, the cycle after the update; busy is low in that cycle, so the next
// request may be taken there, but never while one is still
// in progress. The receiver cannot stall: results must be taken as they
// come. Allocation grants the lowest free register from 1 upward, found
// through a per-row full summary and a search within the row read back.
// No clearing pass follows reset.
module phys_reg_free_list_scoreboard
  import prfl_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic      busy,
  input  wire req_t req,
  output logic      done,
  output resp_t     resp
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic                state;
  logic                accept;
  req_t                cur;
  logic [ROW_W-1:0]    alloc_row;
  logic                alloc_avail;
  logic [CNT_W-1:0]    used_total;
  logic [CNT_W-1:0]    used_total_next;

  logic [ROW_W-1:0]    map_rd_row;
  logic [ROW_BITS-1:0] map_word;
  logic [ROW_W-1:0]    free_row;
  logic                any_free;
  map_wr_t             map_wr;
  ent_t                ent_rd;
  ent_wr_t             ent_wr;

  logic [ROW_BITS-1:0] search_word;
  logic [COL_W-1:0]    free_col;
  logic                col_found;
  logic                addressable;
  logic                used_bit;
  resp_t               resp_next;

  assign busy   = (state == S_EXEC);
  assign accept = start && !busy;

  assign map_rd_row = (req.req_type == REQ_ALLOC) ? free_row : req.reg_index[IDX_W-1:COL_W];

  prfl_used_map u_map (
    .clk     (clk),
    .rst     (rst),
    .rd_row  (map_rd_row),
    .rd_word (map_word),
    .free_row(free_row),
    .any_free(any_free),
    .wr      (map_wr)
  );

  prfl_entry_table u_ent (
    .clk    (clk),
    .rst    (rst),
    .rd_addr(req.reg_index),
    .rd_data(ent_rd),
    .wr     (ent_wr)
  );

  assign search_word = map_word | row_mask(alloc_row);
  assign col_found   = ~&search_word;
  assign addressable = |cur.reg_index;
  assign used_bit    = map_word[cur.reg_index[COL_W-1:0]];

  always_comb begin
    free_col = '0;
    for (int b = ROW_BITS - 1; b >= 0; b--) begin
      if (!search_word[b]) begin
        free_col = COL_W'(b);
      end
    end
  end

  always_comb begin
    map_wr          = '0;
    ent_wr          = '0;
    used_total_next = used_total;
    resp_next       = '0;
    case (cur.req_type)
      REQ_ALLOC: begin
        if (alloc_avail && col_found) begin
          map_wr.we                = 1'b1;
          map_wr.row               = alloc_row;
          map_wr.word              = map_word | (ROW_BITS'(1) << free_col);
          ent_wr.we                = 1'b1;
          ent_wr.addr              = {alloc_row, free_col};
          ent_wr.data.pending      = 1'b1;
          used_total_next          = used_total + CNT_W'(1);
          resp_next.alloc_ok       = 1'b1;
          resp_next.alloc_index    = {alloc_row, free_col};
        end
      end
      REQ_FREE: begin
        if (addressable) begin
          map_wr.we   = 1'b1;
          map_wr.row  = cur.reg_index[IDX_W-1:COL_W];
          map_wr.word = map_word & ~(ROW_BITS'(1) << cur.reg_index[COL_W-1:0]);
          ent_wr.we   = 1'b1;
          ent_wr.addr = cur.reg_index;
          if (used_bit && used_total != '0) begin
            used_total_next = used_total - CNT_W'(1);
          end
        end
      end
      REQ_PRODUCE: begin
        if (addressable) begin
          ent_wr.we               = 1'b1;
          ent_wr.addr             = cur.reg_index;
          ent_wr.data.ready_cycle = cur.ready_at;
        end
      end
      REQ_PENDING: begin
        if (addressable) begin
          ent_wr.we               = 1'b1;
          ent_wr.addr             = cur.reg_index;
          ent_wr.data.pending     = 1'b1;
          ent_wr.data.ready_cycle = ent_rd.ready_cycle;
        end
      end
      REQ_QUERY: begin
        resp_next.is_ready = !addressable ||
                             ((ent_rd.ready_cycle <= cur.now) && !ent_rd.pending);
      end
      default: begin
      end
    endcase
    resp_next.in_use_count = used_total_next;
    if (state != S_EXEC) begin
      map_wr.we = 1'b0;
      ent_wr.we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      done       <= 1'b0;
      used_total <= CNT_W'(ARCH_REGS);
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state      <= S_IDLE;
          done       <= 1'b1;
          used_total <= used_total_next;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur         <= req;
      alloc_row   <= free_row;
      alloc_avail <= any_free && (used_total != CNT_W'(NUM_REGS - 1));
    end
    if (state == S_EXEC) begin
      resp <= resp_next;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/prfl_checker.sv
`default_nettype none

module prfl_checker
  import prfl_pkg::*;
(
  input wire logic  clk,
  input wire logic  rst,
  input wire logic  start,
  input wire logic  busy,
  input wire logic  done,
  input wire resp_t resp
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted transfer did not raise busy");

  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    busy |=> done && !busy)
    else $error("result did not follow the working cycle");

  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without an accepted transfer");

  a_grant_nonzero: assert property (@(posedge clk) disable iff (rst)
    done && resp.alloc_ok |-> resp.alloc_index != '0 && !resp.is_ready)
    else $error("bad grant fields");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    done && !resp.alloc_ok |-> resp.alloc_index == '0)
    else $error("index given without a grant");

endmodule

bind phys_reg_free_list_scoreboard prfl_checker u_prfl_checker (
  .clk  (clk),
  .rst  (rst),
  .start(start),
  .busy (busy),
  .done (done),
  .resp (resp)
);

`default_nettype wire

FILE: verif/tb_phys_reg_free_list_scoreboard.sv
module tb_phys_reg_free_list_scoreboard;
  import prfl_pkg::*;

  localparam int RANDOM_ITEMS = 2000;
  localparam int PHASE_ITEMS  = 150;
  localparam int CALM_TAIL    = 150;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_PRINTED  = 100;

  localparam logic [2:0]       REQ_BAD_FIRST = 3'd5;
  localparam logic [2:0]       REQ_BAD_LAST  = 3'd7;
  localparam logic [CYC_W-1:0] CYC_MAX       = '1;

  logic  clk;
  logic  rst   = 1'b1;
  logic  start = 1'b0;
  req_t  req   = '0;
  logic  busy;
  logic  done;
  resp_t resp;

  req_t  reqs_to_send [$];
  resp_t answers_due [$];

  logic             used_map  [NUM_REGS];
  logic             pend_map  [NUM_REGS];
  logic [CYC_W-1:0] ready_cyc [NUM_REGS];
  int               used_total;

  int n_cycles  = 0;
  int n_errors  = 0;
  int n_sent    = 0;
  int n_planned = 0;
  int idle_left = 0;

  phys_reg_free_list_scoreboard u_dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done),
    .resp  (resp)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) n_cycles <= n_cycles + 1;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    n_errors++;
    if (n_errors <= MAX_PRINTED) begin
      $display("mismatch at cycle %0d: %s got %0h want %0h", n_cycles, what, got, want);
    end
  endtask

  function automatic resp_t pool_answer(input req_t r);
    resp_t a;
    int    k;
    logic  in_pool;
    a = '0;
    in_pool = (r.reg_index != '0) && (int'(r.reg_index) < NUM_REGS);
    case (r.req_type)
      REQ_ALLOC: begin
        if (used_total != NUM_REGS - 1) begin
          k = 1;
          while (k < NUM_REGS && used_map[k]) k++;
          if (k < NUM_REGS) begin
            used_map[k]  = 1'b1;
            pend_map[k]  = 1'b1;
            ready_cyc[k] = '0;
            used_total++;
            a.alloc_ok    = 1'b1;
            a.alloc_index = IDX_W'(k);
          end
        end
      end
      REQ_FREE: begin
        if (in_pool) begin
          if (used_map[r.reg_index] && used_total > 0) used_total--;
          used_map[r.reg_index]  = 1'b0;
          pend_map[r.reg_index]  = 1'b0;
          ready_cyc[r.reg_index] = '0;
        end
      end
      REQ_PRODUCE: begin
        if (in_pool) begin
          ready_cyc[r.reg_index] = r.ready_at;
          pend_map[r.reg_index]  = 1'b0;
        end
      end
      REQ_PENDING: begin
        if (in_pool) pend_map[r.reg_index] = 1'b1;
      end
      REQ_QUERY: begin
        if (r.reg_index == '0) begin
          a.is_ready = 1'b1;
        end else if (int'(r.reg_index) < NUM_REGS) begin
          a.is_ready = (ready_cyc[r.reg_index] <= r.now) && !pend_map[r.reg_index];
        end
      end
      default: begin
      end
    endcase
    a.in_use_count = CNT_W'(used_total);
    return a;
  endfunction

  function automatic req_t make_req(input logic [2:0] kind, input logic [IDX_W-1:0] idx,
                                    input logic [CYC_W-1:0] at, input logic [CYC_W-1:0] cyc);
    req_t r;
    r.req_type  = kind;
    r.reg_index = idx;
    r.ready_at  = at;
    r.now       = cyc;
    return r;
  endfunction

  // hold the item until it is taken; idle in bursts except in calm stretches and the tail
  always @(posedge clk) begin
    if (rst) begin
      start     <= 1'b0;
      idle_left <= 0;
    end else if (!start || !busy) begin
      if (idle_left > 0) begin
        start     <= 1'b0;
        idle_left <= idle_left - 1;
      end else if (reqs_to_send.size() == 0) begin
        start <= 1'b0;
      end else if (n_sent < n_planned - CALM_TAIL && (n_sent / 120) % 4 != 3 &&
                   $urandom_range(0, 11) == 0) begin
        start     <= 1'b0;
        idle_left <= $urandom_range(0, 13);
      end else begin
        req    <= reqs_to_send.pop_front();
        start  <= 1'b1;
        n_sent <= n_sent + 1;
      end
    end
  end

  always @(posedge clk) begin : monitor
    resp_t want;
    if (rst) begin
      for (int k = 0; k < NUM_REGS; k++) begin
        used_map[k]  = (k >= 1) && (k < ARCH_REGS);
        pend_map[k]  = 1'b0;
        ready_cyc[k] = '0;
      end
      used_total = ARCH_REGS;
      answers_due.delete();
    end else begin
      if (done) begin
        if (answers_due.size() == 0) begin
          report_mismatch("result with nothing expected", 32'(resp), '0);
        end else begin
          want = answers_due.pop_front();
          if (resp.alloc_ok !== want.alloc_ok)
            report_mismatch("alloc_ok", 32'(resp.alloc_ok), 32'(want.alloc_ok));
          if (resp.alloc_index !== want.alloc_index)
            report_mismatch("alloc_index", 32'(resp.alloc_index), 32'(want.alloc_index));
          if (resp.is_ready !== want.is_ready)
            report_mismatch("is_ready", 32'(resp.is_ready), 32'(want.is_ready));
          if (resp.in_use_count !== want.in_use_count)
            report_mismatch("in_use_count", 32'(resp.in_use_count),
                            32'(want.in_use_count));
        end
      end
      if (start && !busy) answers_due.push_back(pool_answer(req));
    end
  end

  initial begin
    int               pick;
    logic             filling;
    logic [2:0]       op;
    logic [IDX_W-1:0] idx;
    logic [CYC_W-1:0] at;
    logic [CYC_W-1:0] cyc;

    reqs_to_send.push_back(make_req(REQ_QUERY, 7'd0, $urandom(), '0));
    reqs_to_send.push_back(make_req(REQ_QUERY, 7'd1, $urandom(), '0));
    reqs_to_send.push_back(make_req(REQ_ALLOC, 7'd127, CYC_MAX, CYC_MAX));
    reqs_to_send.push_back(make_req(REQ_QUERY, 7'd64, $urandom(), CYC_MAX));
    reqs_to_send.push_back(make_req(REQ_PRODUCE, 7'd64, CYC_MAX, $urandom()));
    reqs_to_send.push_back(make_req(REQ_QUERY, 7'd64, $urandom(), CYC_MAX - 1));
    reqs_to_send.push_back(make_req(REQ_QUERY, 7'd64, $urandom(), CYC_MAX));
    reqs_to_send.push_back(make_req(REQ_PENDING, 7'd64, $urandom(), $urandom()));
    reqs_to_send.push_back(make_req(REQ_QUERY, 7'd64, $urandom(), CYC_MAX));
    reqs_to_send.push_back(make_req(REQ_PRODUCE, 7'd0, CYC_MAX, $urandom()));
    reqs_to_send.push_back(make_req(REQ_PENDING, 7'd0, $urandom(), $urandom()));
    reqs_to_send.push_back(make_req(REQ_FREE, 7'd0, $urandom(), $urandom()));
    reqs_to_send.push_back(make_req(REQ_QUERY, 7'd0, $urandom(), '0));
    reqs_to_send.push_back(make_req(REQ_FREE, 7'd64, $urandom(), $urandom()));
    reqs_to_send.push_back(make_req(REQ_FREE, 7'd64, $urandom(), $urandom()));
    reqs_to_send.push_back(make_req(REQ_ALLOC, '0, '0, '0));
    reqs_to_send.push_back(make_req(REQ_FREE, 7'd127, $urandom(), $urandom()));
    reqs_to_send.push_back(make_req(REQ_PRODUCE, 7'd127, 32'd5, $urandom()));
    reqs_to_send.push_back(make_req(REQ_QUERY, 7'd127, $urandom(), 32'd4));
    reqs_to_send.push_back(make_req(REQ_QUERY, 7'd127, $urandom(), 32'd5));
    reqs_to_send.push_back(make_req(REQ_FREE, 7'd63, $urandom(), $urandom()));
    reqs_to_send.push_back(make_req(REQ_BAD_FIRST, 7'd127, CYC_MAX, CYC_MAX));
    reqs_to_send.push_back(make_req(REQ_BAD_FIRST + 3'd1, 7'd0, '0, '0));
    reqs_to_send.push_back(make_req(REQ_BAD_LAST, 7'd63, $urandom(), $urandom()));

    // alternate fill-heavy and drain-heavy phases so the pool runs full and back down
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      filling = ((n / PHASE_ITEMS) % 2) == 0;
      pick = $urandom_range(0, 99);
      if (filling) begin
        op = pick < 55 ? REQ_ALLOC : pick < 65 ? REQ_FREE : pick < 77 ? REQ_PRODUCE :
             pick < 85 ? REQ_PENDING : pick < 98 ? REQ_QUERY :
             3'($urandom_range(int'(REQ_BAD_FIRST), int'(REQ_BAD_LAST)));
      end else begin
        op = pick < 10 ? REQ_ALLOC : pick < 55 ? REQ_FREE : pick < 70 ? REQ_PRODUCE :
             pick < 78 ? REQ_PENDING : pick < 97 ? REQ_QUERY :
             3'($urandom_range(int'(REQ_BAD_FIRST), int'(REQ_BAD_LAST)));
      end
      pick = $urandom_range(0, 19);
      idx = pick == 0 ? '0 : pick == 1 ? IDX_W'($urandom()) : IDX_W'($urandom_range(1, NUM_REGS - 1));
      at  = $urandom_range(0, 3) == 0 ? CYC_W'($urandom()) : CYC_W'($urandom_range(0, 63));
      cyc = $urandom_range(0, 3) == 0 ? CYC_W'($urandom()) : CYC_W'($urandom_range(0, 63));
      reqs_to_send.push_back(make_req(op, idx, at, cyc));
    end
    n_planned = reqs_to_send.size();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while ((reqs_to_send.size() != 0 || start || answers_due.size() != 0) &&
           n_cycles < CYCLE_LIMIT) begin
      @(negedge clk);
    end
    if (n_cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
    end else begin
      repeat (DRAIN_CYCLES) @(negedge clk);
      if (n_errors == 0 && answers_due.size() == 0) begin
        $display("CHECK OK");
      end else begin
        $display("CHECK FAILED");
      end
    end
    $finish;
  end

endmodule
